// ----- src/swfp_pkg.sv -----
// ---------------------------------------------------------------------------
// swfp_pkg: shared types and constants for the scale weight frame parser
// Frame delimiters, ASCII codes, digit weights and the result record.
// ---------------------------------------------------------------------------
`default_nettype none

package swfp_pkg;

  // Byte and frame geometry
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WinLen   = 11;
  localparam int unsigned NumDigit = 6;

  // Field widths of one result
  localparam int unsigned WeightW  = 26;
  localparam int unsigned DecW     = 4;
  localparam int unsigned OutDataW = 32;

  // Frame window positions (entry 0 is the oldest byte)
  localparam int unsigned PosSign  = 1;
  localparam int unsigned PosFirst = 2;
  localparam int unsigned PosLast  = 7;
  localparam int unsigned PosDec   = 8;

  // Byte codes
  localparam logic [ByteW-1:0] StxByte   = 8'h02;
  localparam logic [ByteW-1:0] EtxByte   = 8'h03;
  localparam logic [ByteW-1:0] MinusByte = 8'h2D;
  localparam logic [ByteW-1:0] AsciiZero = 8'h30;
  localparam logic [ByteW-1:0] AsciiNine = 8'h39;
  localparam logic [ByteW-1:0] AsciiDecMax = 8'h3F;  // '0' + 15

  // Raw byte sum is reduced by '0' times (10^5 + ... + 1)
  localparam logic [WeightW:0] ZeroOffset = 27'd5333328;
  localparam logic [DecW-1:0]  DecSat     = 4'd15;

  // Digit weights, most significant first
  localparam logic [16:0] PowTen [NumDigit] = '{
    17'd100000, 17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1
  };

  // One parsed frame
  typedef struct packed {
    logic                      digit_error;
    logic                      decimals_saturated;
    logic [DecW-1:0]           decimals;
    logic signed [WeightW-1:0] weight;
  } result_t;

endpackage

`default_nettype wire

// ----- src/scale_weight_frame_parser_unit.sv -----
// ---------------------------------------------------------------------------
// scale_weight_frame_parser_unit: ASCII weighing indicator frame parser
// Scans a byte stream for STX ... ETX frames and turns each into a weight.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis_* carries received bytes, one per request. The last eleven bytes
//   are held in a shift window; when an ETX byte arrives and the oldest
//   window byte is STX, the twelve bytes form a frame and one result request
//   is issued on m_axis_*. Other bytes produce no output.
//   cfg_we_i/cfg_wdata_i write the reverse_digits bit; write only while idle.
// Throughput: one input byte per cycle while s_axis_tready is high, set by
//   the single result register stage; the conversion is six constant
//   multiply-adds in combinational logic. A frame result is registered in
//   the result register, or in the skid register if the result register stalls.
// Stall: a skid register behind the result register holds one extra
//   result, so input is still taken while a result waits. s_axis_tready
//   drops only when both are full.
// Reset: rst_ni clears the byte window (no frame can match until eleven
//   bytes have arrived), the output valids and reverse_digits.
// ---------------------------------------------------------------------------
`default_nettype none

module scale_weight_frame_parser_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration: bit 0 = reverse_digits
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i,
  // Input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [swfp_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  // Output stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [25:0] weight, [29:26] decimals, [30] decimals_saturated, [31] digit_error
  output logic [swfp_pkg::OutDataW-1:0]      m_axis_tdata
);
  import swfp_pkg::*;

  logic [ByteW-1:0] win_q [WinLen];
  logic             rev_q;
  logic             s_fire, m_fire, frame_hit;
  result_t          res;
  result_t          out_q, skid_q;
  logic             out_valid_q, skid_valid_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q <= 1'b0;
    end else if (cfg_we_i) begin
      rev_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !skid_valid_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = out_valid_q && m_axis_tready;

  // Byte window: shift in on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinLen; i++) begin
        win_q[i] <= '0;
      end
    end else if (s_fire) begin
      for (int i = 0; i < WinLen - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WinLen-1] <= s_axis_tdata;
    end
  end

  assign frame_hit = (s_axis_tdata == EtxByte) && (win_q[0] == StxByte);

  // Frame conversion
  always_comb begin
    logic [ByteW-1:0]  dig;
    logic [WeightW:0]  raw_sum;
    logic [WeightW:0]  mag;
    logic              derr;
    logic [ByteW-1:0]  dec_b;
    raw_sum = '0;
    derr    = 1'b0;
    for (int i = 0; i < NumDigit; i++) begin
      dig = rev_q ? win_q[PosLast - i] : win_q[PosFirst + i];
      if (dig < AsciiZero || dig > AsciiNine) begin
        derr = 1'b1;
      end
      raw_sum = raw_sum + ((WeightW+1)'(dig) * (WeightW+1)'(PowTen[i]));
    end
    mag = raw_sum - ZeroOffset;
    res.weight      = (win_q[PosSign] == MinusByte) ? WeightW'(-mag) : WeightW'(mag);
    res.digit_error = derr;

    // Decimal count: clamp to 0..15
    dec_b = win_q[PosDec];
    if (dec_b < AsciiZero) begin
      res.decimals           = '0;
      res.decimals_saturated = 1'b0;
    end else if (dec_b > AsciiDecMax) begin
      res.decimals           = DecSat;
      res.decimals_saturated = 1'b1;
    end else begin
      res.decimals           = DecW'(dec_b - AsciiZero);
      res.decimals_saturated = 1'b0;
    end
  end

  // Result register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (m_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !m_fire) begin
      if (s_fire && frame_hit) begin
        skid_valid_q <= 1'b1;
      end
    end else begin
      out_valid_q <= s_fire && frame_hit;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (m_fire) begin
        out_q <= skid_q;
      end
    end else if (out_valid_q && !m_fire) begin
      if (s_fire && frame_hit) begin
        skid_q <= res;
      end
    end else if (s_fire && frame_hit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire

// ----- src/swfp_checker.sv -----
// ---------------------------------------------------------------------------
// swfp_checker: port-level checks for the scale weight frame parser
// Watches the stream ports only; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module swfp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [swfp_pkg::ByteW-1:0]    s_axis_tdata,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [swfp_pkg::OutDataW-1:0] m_axis_tdata
);
  import swfp_pkg::*;

  // A stalled result holds its data
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("swfp: stalled result changed");

  // A fresh result follows an accepted ETX byte
  a_etx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && (s_axis_tdata == EtxByte)))
    else $error("swfp: result without ETX request");

  // Saturation flag implies clamped count
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[30] |-> (m_axis_tdata[29:26] == DecSat))
    else $error("swfp: saturated count not 15");

  // Input back-pressure only while results are pending
  a_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("swfp: tready low with no result pending");

endmodule

bind scale_weight_frame_parser_unit swfp_checker u_swfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
